FILE: hw/rtl/fbfla_pkg.sv
// Package for the fixed block free list allocator.
// Holds pool sizes, field widths, operation and status codes.
// No dependencies.
package fbfla_pkg;

   // Pool geometry
   localparam int POOL_DEPTH = 1024;
   localparam int ALIGNMENT  = 16;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int LINK_W     = IDX_W + 1;
   localparam int ALIGN_SH   = $clog2(ALIGNMENT);

   // Field widths
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int SIZE_W    = 13;
   localparam int COUNT_W   = 11;
   localparam int RSIZE_W   = SIZE_W + 1;
   localparam int OFFSET_W  = 22;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   // End of chain mark
   localparam logic [LINK_W-1:0] END_MARK = LINK_W'(POOL_DEPTH);

   // Register reset values
   localparam logic [SIZE_W-1:0]  RST_SIZE  = SIZE_W'(8);
   localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(1024);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

   // Round a size up to the alignment
   function automatic logic [RSIZE_W-1:0] round_size(input logic [SIZE_W-1:0] size);
      logic [RSIZE_W-1:0] sum;
      sum = RSIZE_W'(size) + RSIZE_W'(ALIGNMENT - 1);
      return sum & ~RSIZE_W'(ALIGNMENT - 1);
   endfunction

   // Saturate a count to the pool depth
   function automatic logic [LINK_W-1:0] sat_count(input logic [COUNT_W-1:0] cnt);
      logic [LINK_W:0] wide;
      wide = (LINK_W + 1)'(cnt);
      return (wide > (LINK_W + 1)'(POOL_DEPTH)) ? END_MARK : wide[LINK_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/fixed_block_free_list_allocator_core.sv
// Fixed block free list allocator: LIFO free list of equal blocks in one link memory.
// Depends on fbfla_pkg.
//
//  channel | direction | beat content
//  --------+-----------+-----------------------------------------------
//  req_    | in        | op, free_index
//  rsp_    | out       | status, block_index, byte_offset
//  csr_    | in        | csr_index, csr_wdata (write only, always ready)
//
// Free, rejected requests and unused codes answer straight into the output register; a
// successful allocate first does a registered read of the head's link in ST_LOOKUP.
// Rebuild answers at once, then sweeps all POOL_DEPTH (1024) link memory entries, one
// entry a cycle, with req_ready low throughout. Reset starts the same sweep.
// A result waiting in the output register holds req_ready low until its beat is taken.
module fixed_block_free_list_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fbfla_pkg::OP_W-1:0]        req_op,
   input  logic [fbfla_pkg::IDX_W-1:0]       req_free_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fbfla_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fbfla_pkg::IDX_W-1:0]       rsp_block_index,
   output logic [fbfla_pkg::OFFSET_W-1:0]    rsp_byte_offset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbfla_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbfla_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   localparam int IDX_W    = fbfla_pkg::IDX_W;
   localparam int LINK_W   = fbfla_pkg::LINK_W;
   localparam int RSIZE_W  = fbfla_pkg::RSIZE_W;
   localparam int OFFSET_W = fbfla_pkg::OFFSET_W;
   localparam int PROD_W   = IDX_W + RSIZE_W;

   // Controller states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_SWEEP  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [fbfla_pkg::SIZE_W-1:0]      cfg_size_ff, cfg_size_in;
   logic [fbfla_pkg::COUNT_W-1:0]     cfg_count_ff, cfg_count_in;
   logic [RSIZE_W-1:0]                used_size_ff, used_size_in;
   logic [LINK_W-1:0]                 used_count_ff, used_count_in;
   logic [LINK_W-1:0]                 head_ff, head_in;
   logic [IDX_W-1:0]                  sweep_ff, sweep_in;
   logic [OFFSET_W-1:0]               off_ff, off_in;
   logic [LINK_W-1:0]                 rd_data_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fbfla_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]                  rsp_index_ff, rsp_index_in;
   logic [OFFSET_W-1:0]               rsp_offset_ff, rsp_offset_in;

   logic                              slot_free;
   logic                              req_fire;
   logic                              mem_we;
   logic [IDX_W-1:0]                  mem_waddr;
   logic [LINK_W-1:0]                 mem_wdata;
   logic                              mem_re;
   logic [PROD_W-1:0]                 product;
   logic [LINK_W-1:0]                 sweep_next;

   // Link memory: one write port, one registered read port
   logic [LINK_W-1:0] link_mem [fbfla_pkg::POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

   // Handshakes
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_index_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   // Offset of the current head block
   assign product    = PROD_W'(head_ff[IDX_W-1:0]) * PROD_W'(used_size_ff);
   assign sweep_next = LINK_W'(sweep_ff) + LINK_W'(1);

   // Configuration writes
   always_comb begin
      cfg_size_in  = cfg_size_ff;
      cfg_count_in = cfg_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fbfla_pkg::REG_BLOCK_SIZE:  cfg_size_in  = csr_wdata[fbfla_pkg::SIZE_W-1:0];
            fbfla_pkg::REG_BLOCK_COUNT: cfg_count_in = csr_wdata[fbfla_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Controller
   always_comb begin
      state_in      = state_ff;
      used_size_in  = used_size_ff;
      used_count_in = used_count_ff;
      head_in       = head_ff;
      sweep_in      = sweep_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      mem_we        = 1'b0;
      mem_waddr     = req_free_index;
      mem_wdata     = head_ff;
      mem_re        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in = fbfla_pkg::STS_OK;
               rsp_index_in  = '0;
               rsp_offset_in = '0;
               case (req_op)
                  fbfla_pkg::OP_ALLOC: begin
                     if (head_ff >= used_count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = fbfla_pkg::STS_EMPTY;
                     end else begin
                        // Read the head's link, finish next cycle
                        mem_re   = 1'b1;
                        off_in   = product[OFFSET_W-1:0];
                        state_in = ST_LOOKUP;
                     end
                  end
                  fbfla_pkg::OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (LINK_W'(req_free_index) >= used_count_ff) begin
                        rsp_status_in = fbfla_pkg::STS_RANGE;
                     end else begin
                        // Push onto the head
                        mem_we  = 1'b1;
                        head_in = LINK_W'(req_free_index);
                     end
                  end
                  fbfla_pkg::OP_REBUILD: begin
                     // Latch the registers and start the sweep
                     rsp_valid_in  = 1'b1;
                     used_size_in  = fbfla_pkg::round_size(cfg_size_ff);
                     used_count_in = fbfla_pkg::sat_count(cfg_count_ff);
                     head_in       = (fbfla_pkg::sat_count(cfg_count_ff) == '0) ?
                                     fbfla_pkg::END_MARK : '0;
                     sweep_in      = '0;
                     state_in      = ST_SWEEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            // Pop the head once the output register is free
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fbfla_pkg::STS_OK;
               rsp_index_in  = head_ff[IDX_W-1:0];
               rsp_offset_in = off_ff;
               head_in       = rd_data_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // Chain entry to its successor, or end the chain
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = (sweep_next < used_count_ff) ? sweep_next : fbfla_pkg::END_MARK;
            sweep_in  = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(fbfla_pkg::POOL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         cfg_size_ff   <= fbfla_pkg::RST_SIZE;
         cfg_count_ff  <= fbfla_pkg::RST_COUNT;
         used_size_ff  <= fbfla_pkg::round_size(fbfla_pkg::RST_SIZE);
         used_count_ff <= fbfla_pkg::sat_count(fbfla_pkg::RST_COUNT);
         head_ff       <= (fbfla_pkg::sat_count(fbfla_pkg::RST_COUNT) == '0) ?
                          fbfla_pkg::END_MARK : '0;
         sweep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_size_ff   <= cfg_size_in;
         cfg_count_ff  <= cfg_count_in;
         used_size_ff  <= used_size_in;
         used_count_ff <= used_count_in;
         head_ff       <= head_in;
         sweep_ff      <= sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      off_ff        <= off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
   end

endmodule
